// ===== rtl/core/dpi_pkg.sv =====
// shared constants, types and helpers for the damped pseudo-inverse block
`default_nettype none
package dpi_pkg;

    localparam int MAX_ROWS  = 6;
    localparam int MAX_COLS  = 8;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int AUG_W     = 2 * MAX_ROWS;
    localparam int JDEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADEPTH    = MAX_ROWS * AUG_W;
    localparam int JAW       = $clog2(JDEPTH);
    localparam int AAW       = $clog2(ADEPTH);
    localparam int ROWS_W    = 3;
    localparam int COLS_W    = 4;
    localparam int DAMP_W    = 31;
    localparam int RND_W     = 2 * DATA_W - FRAC_BITS;
    localparam int ACC_W     = RND_W + 4;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int DCNT_W    = $clog2(NUM_W + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 2'd2;

    localparam logic signed [DATA_W-1:0] FX_ONE  = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] FX_ZERO = '0;

    typedef enum logic [4:0] {
        S_LOAD,
        S_A_RD1, S_A_RD2, S_A_MUL, S_A_ACC, S_A_WR1, S_A_WR2,
        S_G_PIV, S_G_PCHK, S_G_SRCH_RD, S_G_SRCH_CHK,
        S_G_SW_RD1, S_G_SW_RD2, S_G_SW_WR1, S_G_SW_WR2,
        S_G_NRD, S_G_NDIV, S_G_NWAIT,
        S_G_EL_F, S_G_EL_FW, S_G_EL_RD1, S_G_EL_RD2, S_G_EL_MUL, S_G_EL_WR,
        S_O_RD1, S_O_MUL, S_O_ACC, S_O_ZERO, S_O_WAIT
    } t_state;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] num;
        logic signed [DATA_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quot;
    } t_div_rsp;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - ACC_W'(1);
        if (v > hi) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/damped_pseudo_inverse_top.sv =====
// Damped least-squares pseudo-inverse: loads J row-major, emits J^T (J J^T + damping I)^-1.
// Jacobian elements are taken while the block loads; the rows*cols-th element starts the solve,
// during which no element is taken. The solve runs on one shared multiplier and one 48-step
// divider: it forms J*J^T, inverts it by pivot division plus elimination, then computes each
// result (m rows, n columns) and holds it while the output stalls. A singular matrix skips
// straight to emitting zeros, each held until it is taken.
`default_nettype none
module damped_pseudo_inverse_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [dpi_pkg::DATA_W-1:0]     i_jacobian_element,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [dpi_pkg::DATA_W-1:0]          o_pinv_element,
    output logic                                       o_last_element,
    output logic                                       o_singular,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [dpi_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [dpi_pkg::DAMP_W-1:0]            i_cfg_data
);
    import dpi_pkg::*;

    t_state r_state, n_state;

    logic [ROWS_W-1:0]       r_rows_cfg;
    logic [COLS_W-1:0]       r_cols_cfg;
    logic [DAMP_W-1:0]       r_damping;
    logic [JAW-1:0]          r_load_cnt;
    logic [ROWS_W-1:0]       m;
    logic [COLS_W-1:0]       n;
    logic [JAW-1:0]          total;

    logic [ROWS_W-1:0]       r_i;
    logic [COLS_W-1:0]       r_j;
    logic [ROWS_W-1:0]       r_k;
    logic [COLS_W-1:0]       r_oi;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [DATA_W-1:0] r_ta, r_tb, r_factor, r_piv;
    logic signed [DATA_W-1:0] r_out;
    logic                    r_oval, r_last, r_sing;

    logic signed [DATA_W-1:0] jmem [JDEPTH];
    logic signed [DATA_W-1:0] amem [ADEPTH];
    logic signed [DATA_W-1:0] r_jrd, r_ard;
    logic [JAW-1:0]          jaddr;
    logic [AAW-1:0]          aaddr, awaddr;
    logic                    awe;
    logic signed [DATA_W-1:0] awdata;

    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [RND_W-1:0]  mul_rnd;
    t_div_req                div_req;
    t_div_rsp                div_rsp;

    logic cfg_hit, in_acc, out_acc;
    logic j_end, k_end, i_end, oj_end, oi_end;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  elim_diff;
    logic signed [DATA_W-1:0] elim_prod;

    assign m = (r_rows_cfg == '0) ? ROWS_W'(1) :
               (int'(r_rows_cfg) > MAX_ROWS) ? ROWS_W'(MAX_ROWS) : r_rows_cfg;
    assign n = (r_cols_cfg == '0) ? COLS_W'(1) :
               (int'(r_cols_cfg) > MAX_COLS) ? COLS_W'(MAX_COLS) : r_cols_cfg;
    assign total = JAW'(int'(m) * int'(n));

    assign o_cfg_ready = 1'b1;
    assign cfg_hit = i_cfg_valid && (i_cfg_index == CFG_ROWS || i_cfg_index == CFG_COLS ||
                                     i_cfg_index == CFG_DAMPING);
    assign o_stall = (r_state != S_LOAD);
    assign in_acc  = i_valid && !o_stall;
    assign o_valid = r_oval;
    assign out_acc = r_oval && !i_stall;
    assign o_pinv_element = r_out;
    assign o_last_element = r_last;
    assign o_singular     = r_sing;

    assign j_end  = (int'(r_j) == 2 * int'(m) - 1);
    assign k_end  = (int'(r_k) == int'(m) - 1);
    assign i_end  = (int'(r_i) == int'(m) - 1);
    assign oj_end = (int'(r_j) == int'(m) - 1);
    assign oi_end = (int'(r_oi) == int'(n) - 1);

    assign acc_next  = r_acc + ACC_W'(mul_rnd);
    assign elim_prod = sat32(ACC_W'(mul_rnd));
    assign elim_diff = ACC_W'(r_tb) - ACC_W'(elim_prod);

    dpi_mul u_mul (
        .i_clk   (i_clk),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_round (mul_rnd)
    );

    dpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // memories
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            jmem[r_load_cnt] <= i_jacobian_element;
        end
        r_jrd <= jmem[jaddr];
    end

    always_ff @(posedge i_clk) begin
        if (awe) begin
            amem[awaddr] <= awdata;
        end
        r_ard <= amem[aaddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:       if (in_acc && r_load_cnt == total - JAW'(1)) n_state = S_A_RD1;
            S_A_RD1:      n_state = S_A_RD2;
            S_A_RD2:      n_state = S_A_MUL;
            S_A_MUL:      n_state = S_A_ACC;
            S_A_ACC:      n_state = (int'(r_k) == int'(n) - 1) ? S_A_WR1 : S_A_RD1;
            S_A_WR1:      n_state = S_A_WR2;
            S_A_WR2:      n_state = (oj_end && i_end) ? S_G_PIV : S_A_RD1;
            S_G_PIV:      n_state = S_G_PCHK;
            S_G_PCHK: begin
                if (r_ard != '0) n_state = S_G_NRD;
                else if (i_end) n_state = S_O_ZERO;
                else n_state = S_G_SRCH_RD;
            end
            S_G_SRCH_RD:  n_state = S_G_SRCH_CHK;
            S_G_SRCH_CHK: begin
                if (r_ard != '0) n_state = S_G_SW_RD1;
                else if (k_end) n_state = S_O_ZERO;
                else n_state = S_G_SRCH_RD;
            end
            S_G_SW_RD1:   n_state = S_G_SW_RD2;
            S_G_SW_RD2:   n_state = S_G_SW_WR1;
            S_G_SW_WR1:   n_state = S_G_SW_WR2;
            S_G_SW_WR2:   n_state = j_end ? S_G_PIV : S_G_SW_RD1;
            S_G_NRD:      n_state = S_G_NDIV;
            S_G_NDIV:     n_state = S_G_NWAIT;
            S_G_NWAIT:    if (div_rsp.done) n_state = j_end ? S_G_EL_F : S_G_NRD;
            S_G_EL_F: begin
                if (r_k != r_i) n_state = S_G_EL_FW;
                else if (k_end) n_state = i_end ? S_O_RD1 : S_G_PIV;
            end
            S_G_EL_FW:    n_state = S_G_EL_RD1;
            S_G_EL_RD1:   n_state = S_G_EL_RD2;
            S_G_EL_RD2:   n_state = S_G_EL_MUL;
            S_G_EL_MUL:   n_state = S_G_EL_WR;
            S_G_EL_WR: begin
                if (!j_end) n_state = S_G_EL_RD1;
                else if (!k_end) n_state = S_G_EL_F;
                else n_state = i_end ? S_O_RD1 : S_G_PIV;
            end
            S_O_RD1:      n_state = S_O_MUL;
            S_O_MUL:      n_state = S_O_ACC;
            S_O_ACC:      n_state = k_end ? S_O_WAIT : S_O_RD1;
            S_O_ZERO:     n_state = S_O_WAIT;
            S_O_WAIT: begin
                if (out_acc) begin
                    if (r_last) n_state = S_LOAD;
                    else n_state = r_sing ? S_O_ZERO : S_O_RD1;
                end
            end
            default:      n_state = S_LOAD;
        endcase
    end

    // datapath controls
    always_comb begin
        jaddr   = '0;
        aaddr   = '0;
        awe     = 1'b0;
        awaddr  = '0;
        awdata  = r_ard;
        mul_a   = r_ta;
        mul_b   = r_jrd;
        div_req = '{start: 1'b0, num: r_ard, den: r_piv};
        case (r_state)
            S_A_RD1: jaddr = JAW'(int'(r_i) * int'(n) + int'(r_k));
            S_A_RD2: jaddr = JAW'(int'(r_j) * int'(n) + int'(r_k));
            S_A_WR1: begin
                awe    = 1'b1;
                awaddr = AAW'(int'(r_i) * AUG_W + int'(r_j));
                awdata = sat32(r_acc + ((int'(r_i) == int'(r_j)) ?
                               ACC_W'(r_damping) : ACC_W'(0)));
            end
            S_A_WR2: begin
                awe    = 1'b1;
                awaddr = AAW'(int'(r_i) * AUG_W + int'(m) + int'(r_j));
                awdata = (int'(r_i) == int'(r_j)) ? FX_ONE : FX_ZERO;
            end
            S_G_PIV:     aaddr = AAW'(int'(r_i) * AUG_W + int'(r_i));
            S_G_SRCH_RD: aaddr = AAW'(int'(r_k) * AUG_W + int'(r_i));
            S_G_SW_RD1:  aaddr = AAW'(int'(r_i) * AUG_W + int'(r_j));
            S_G_SW_RD2:  aaddr = AAW'(int'(r_k) * AUG_W + int'(r_j));
            S_G_SW_WR1: begin
                awe    = 1'b1;
                awaddr = AAW'(int'(r_i) * AUG_W + int'(r_j));
                awdata = r_ard;
            end
            S_G_SW_WR2: begin
                awe    = 1'b1;
                awaddr = AAW'(int'(r_k) * AUG_W + int'(r_j));
                awdata = r_ta;
            end
            S_G_NRD:     aaddr = AAW'(int'(r_i) * AUG_W + int'(r_j));
            S_G_NDIV:    div_req.start = 1'b1;
            S_G_NWAIT: begin
                awe    = div_rsp.done;
                awaddr = AAW'(int'(r_i) * AUG_W + int'(r_j));
                awdata = div_rsp.quot;
            end
            S_G_EL_F:    aaddr = AAW'(int'(r_k) * AUG_W + int'(r_i));
            S_G_EL_RD1:  aaddr = AAW'(int'(r_i) * AUG_W + int'(r_j));
            S_G_EL_RD2:  aaddr = AAW'(int'(r_k) * AUG_W + int'(r_j));
            S_G_EL_MUL: begin
                mul_a = r_factor;
                mul_b = r_ta;
            end
            S_G_EL_WR: begin
                awe    = 1'b1;
                awaddr = AAW'(int'(r_k) * AUG_W + int'(r_j));
                awdata = sat32(elim_diff);
            end
            S_O_RD1: begin
                jaddr = JAW'(int'(r_k) * int'(n) + int'(r_oi));
                aaddr = AAW'(int'(r_k) * AUG_W + int'(m) + int'(r_j));
            end
            S_O_MUL: begin
                mul_a = r_jrd;
                mul_b = r_ard;
            end
            default: ;
        endcase
    end

    // state, configuration and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_rows_cfg <= ROWS_W'(6);
            r_cols_cfg <= COLS_W'(6);
            r_damping  <= '0;
            r_load_cnt <= '0;
            r_oval     <= 1'b0;
            r_sing     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROWS:    r_rows_cfg <= i_cfg_data[ROWS_W-1:0];
                    CFG_COLS:    r_cols_cfg <= i_cfg_data[COLS_W-1:0];
                    CFG_DAMPING: r_damping  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                r_load_cnt <= '0;
            end else if (in_acc) begin
                r_load_cnt <= (r_load_cnt == total - JAW'(1)) ? '0 : r_load_cnt + JAW'(1);
            end
            if (r_state == S_LOAD && n_state == S_A_RD1) begin
                r_sing <= 1'b0;
            end else if ((r_state == S_G_PCHK || r_state == S_G_SRCH_CHK) &&
                         n_state == S_O_ZERO) begin
                r_sing <= 1'b1;
            end
            if (r_state == S_O_ZERO || (r_state == S_O_ACC && k_end)) begin
                r_oval <= 1'b1;
            end else if (out_acc) begin
                r_oval <= 1'b0;
            end
        end
    end

    // loop counters and working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                r_i   <= '0;
                r_j   <= '0;
                r_k   <= '0;
                r_oi  <= '0;
                r_acc <= '0;
            end
            S_A_RD2: r_ta <= r_jrd;
            S_A_ACC: begin
                r_acc <= acc_next;
                r_k   <= (int'(r_k) == int'(n) - 1) ? '0 : r_k + ROWS_W'(1);
            end
            S_A_WR2: begin
                r_acc <= '0;
                if (oj_end) begin
                    r_j <= '0;
                    r_i <= i_end ? '0 : r_i + ROWS_W'(1);
                end else begin
                    r_j <= r_j + COLS_W'(1);
                end
            end
            S_G_PCHK: begin
                r_piv <= r_ard;
                r_j   <= '0;
                r_k   <= r_i + ROWS_W'(1);
                if (r_ard == '0 && i_end) begin
                    r_oi <= '0;
                end
            end
            S_G_SRCH_CHK: begin
                r_j <= '0;
                if (r_ard == '0 && !k_end) r_k <= r_k + ROWS_W'(1);
                if (r_ard == '0 && k_end) r_oi <= '0;
            end
            S_G_SW_RD2: r_ta <= r_ard;
            S_G_SW_WR2: r_j <= j_end ? '0 : r_j + COLS_W'(1);
            S_G_NWAIT: begin
                if (div_rsp.done) begin
                    r_j <= j_end ? '0 : r_j + COLS_W'(1);
                    if (j_end) r_k <= '0;
                end
            end
            S_G_EL_F: begin
                if (r_k == r_i) begin
                    if (!k_end) begin
                        r_k <= r_k + ROWS_W'(1);
                    end else begin
                        r_k   <= '0;
                        r_j   <= '0;
                        r_oi  <= '0;
                        r_acc <= '0;
                        r_i   <= i_end ? '0 : r_i + ROWS_W'(1);
                    end
                end
            end
            S_G_EL_FW: begin
                r_factor <= r_ard;
                r_j      <= '0;
            end
            S_G_EL_RD2: r_ta <= r_ard;
            S_G_EL_MUL: r_tb <= r_ard;
            S_G_EL_WR: begin
                if (!j_end) begin
                    r_j <= r_j + COLS_W'(1);
                end else begin
                    r_j <= '0;
                    if (!k_end) begin
                        r_k <= r_k + ROWS_W'(1);
                    end else begin
                        r_k   <= '0;
                        r_oi  <= '0;
                        r_acc <= '0;
                        r_i   <= i_end ? '0 : r_i + ROWS_W'(1);
                    end
                end
            end
            S_O_ACC: begin
                if (k_end) begin
                    r_out  <= sat32(acc_next);
                    r_last <= oi_end && oj_end;
                    r_k    <= '0;
                    r_acc  <= '0;
                end else begin
                    r_acc <= acc_next;
                    r_k   <= r_k + ROWS_W'(1);
                end
            end
            S_O_ZERO: begin
                r_out  <= FX_ZERO;
                r_last <= oi_end && oj_end;
            end
            S_O_WAIT: begin
                if (out_acc) begin
                    if (oj_end) begin
                        r_j  <= '0;
                        r_oi <= r_oi + COLS_W'(1);
                    end else begin
                        r_j <= r_j + COLS_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/dpi_mul.sv =====
// shared signed multiplier with registered product and round-to-nearest scaling
`default_nettype none
module dpi_mul (
    input  wire logic                                i_clk,
    input  wire logic signed [dpi_pkg::DATA_W-1:0]   i_a,
    input  wire logic signed [dpi_pkg::DATA_W-1:0]   i_b,
    output logic signed [dpi_pkg::RND_W-1:0]         o_round
);
    import dpi_pkg::*;

    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [2*DATA_W-1:0] rnd_sum;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // add half an lsb, then floor shift
    assign rnd_sum = r_prod + ((2*DATA_W)'(1) << (FRAC_BITS - 1));
    assign o_round = RND_W'(rnd_sum >>> FRAC_BITS);

endmodule
`default_nettype wire

// ===== rtl/core/dpi_div.sv =====
// iterative restoring divider, one quotient bit per cycle, scaled fixed-point quotient
`default_nettype none
module dpi_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dpi_pkg::t_div_req  i_req,
    output dpi_pkg::t_div_rsp       o_rsp
);
    import dpi_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DCNT_W-1:0]    r_cnt;
    logic [NUM_W-1:0]     r_q;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_dmag;
    logic                 r_neg;
    logic [DATA_W:0]      trial;
    logic [DATA_W:0]      dmag_ext;
    logic                 qbit;
    logic [NUM_W-1:0]     nmag;
    logic [DATA_W-1:0]    dmag;
    logic signed [NUM_W:0] qs;

    // magnitude of num * 2^FRAC_BITS
    assign nmag = i_req.num[DATA_W-1] ? NUM_W'(-{{FRAC_BITS{i_req.num[DATA_W-1]}}, i_req.num,
                                                 {FRAC_BITS{1'b0}}})
                                      : NUM_W'({i_req.num, {FRAC_BITS{1'b0}}});
    assign dmag = i_req.den[DATA_W-1] ? DATA_W'(-i_req.den) : DATA_W'(i_req.den);

    assign trial    = {r_rem, r_q[NUM_W-1]};
    assign dmag_ext = {1'b0, r_dmag};
    assign qbit     = (trial >= dmag_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q    <= nmag;
            r_rem  <= '0;
            r_dmag <= dmag;
            r_neg  <= i_req.num[DATA_W-1] ^ i_req.den[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= qbit ? DATA_W'(trial - dmag_ext) : DATA_W'(trial);
            r_q   <= {r_q[NUM_W-2:0], qbit};
        end
    end

    assign qs = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

    assign o_rsp.done = r_done;
    assign o_rsp.quot = sat32(ACC_W'(qs));

endmodule
`default_nettype wire

// ===== rtl/core/dpi_checker.sv =====
// port-level checks for the damped pseudo-inverse block, bound to the top level
`default_nettype none
module dpi_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_stall,
    input wire logic                               o_valid,
    input wire logic                               i_stall,
    input wire logic signed [dpi_pkg::DATA_W-1:0]  o_pinv_element,
    input wire logic                               o_last_element,
    input wire logic                               o_singular
);
    import dpi_pkg::*;

    // no element is taken while a result waits
    a_no_load_during_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("element channel open while a result is pending");

    // a singular solve emits only zeros
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (o_pinv_element == '0))
        else $error("nonzero result on singular matrix");

    // after the last result the block opens for a new load
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_element) |=> (!o_valid && !o_stall))
        else $error("block did not return to loading after last result");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pinv_element)))
        else $error("stalled result changed");

    // reset clears the result channel
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind damped_pseudo_inverse_top dpi_checker u_dpi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_pinv_element (o_pinv_element),
    .o_last_element (o_last_element),
    .o_singular     (o_singular)
);
`default_nettype wire
